[rtl/gwr_pkg.sv]
// Shared types, widths and codes for the grid window rotator.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none

package gwr_pkg;

   localparam int MAX_SIDE = 32;
   localparam int RST_SIDE = (MAX_SIDE < 32) ? MAX_SIDE : 32;

   localparam int FUNC_W  = 2;
   localparam int COORD_W = 6;
   localparam int RAD_W   = 4;
   localparam int CSR_W   = 6;
   localparam int VAL_W   = 11;
   localparam int WIN_W   = RAD_W + 1;

   localparam int IDX_W  = $clog2(MAX_SIDE);
   localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CNT_W  = (IDX_W > WIN_W) ? IDX_W : WIN_W;
   localparam int CMP_W  = ((SIDE_W > COORD_W) ? SIDE_W : COORD_W) + 1;

   localparam logic [CSR_W-1:0] CSR_RST = CSR_W'(32);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INIT   = 2'd0,
      FUNC_ROTATE = 2'd1,
      FUNC_READ   = 2'd2
   } func_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [COORD_W-1:0] center_row;
      logic [COORD_W-1:0] center_col;
      logic [RAD_W-1:0]   radius;
      logic               direction;
   } req_type;

   typedef struct packed {
      logic              valid;
      logic [VAL_W-1:0]  cell_value;
      logic              status;
   } res_type;

   typedef struct packed {
      logic              grid_we;
      logic              grid_wsel_win;
      logic [ADDR_W-1:0] grid_waddr;
      logic [VAL_W-1:0]  grid_wdata;
      logic [ADDR_W-1:0] grid_raddr;
      logic              win_we;
      logic [ADDR_W-1:0] win_waddr;
      logic [ADDR_W-1:0] win_raddr;
   } mem_ctl_type;

endpackage

`default_nettype wire

[rtl/gwr_agen.sv]
// Address unit: maps a base plus offset cell position to a grid address,
// and a window position to a scratch address. Depends on gwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwr_agen (
   input  wire logic [gwr_pkg::IDX_W-1:0]  base_row,
   input  wire logic [gwr_pkg::IDX_W-1:0]  base_col,
   input  wire logic [gwr_pkg::CNT_W-1:0]  off_row,
   input  wire logic [gwr_pkg::CNT_W-1:0]  off_col,
   input  wire logic [gwr_pkg::CNT_W-1:0]  win_row,
   input  wire logic [gwr_pkg::CNT_W-1:0]  win_col,
   output logic      [gwr_pkg::ADDR_W-1:0] grid_addr,
   output logic      [gwr_pkg::ADDR_W-1:0] win_addr
);

   logic [gwr_pkg::CNT_W:0]   row_sum;
   logic [gwr_pkg::CNT_W:0]   col_sum;
   logic [gwr_pkg::IDX_W-1:0] row_idx;
   logic [gwr_pkg::IDX_W-1:0] col_idx;

   assign row_sum = (gwr_pkg::CNT_W+1)'(base_row) + (gwr_pkg::CNT_W+1)'(off_row);
   assign col_sum = (gwr_pkg::CNT_W+1)'(base_col) + (gwr_pkg::CNT_W+1)'(off_col);
   assign row_idx = row_sum[gwr_pkg::IDX_W-1:0];
   assign col_idx = col_sum[gwr_pkg::IDX_W-1:0];

   assign grid_addr = gwr_pkg::ADDR_W'(row_idx) * gwr_pkg::ADDR_W'(gwr_pkg::MAX_SIDE)
                    + gwr_pkg::ADDR_W'(col_idx);
   assign win_addr  = gwr_pkg::ADDR_W'(win_row[gwr_pkg::IDX_W-1:0])
                      * gwr_pkg::ADDR_W'(gwr_pkg::MAX_SIDE)
                    + gwr_pkg::ADDR_W'(win_col[gwr_pkg::IDX_W-1:0]);

endmodule

`default_nettype wire

[rtl/gwr_store.sv]
// Grid memory and window scratch memory, one write and one registered
// read port each. Depends on gwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwr_store (
   input  wire logic                      clock,
   input  wire gwr_pkg::mem_ctl_type      ctl,
   output logic      [gwr_pkg::VAL_W-1:0] grid_rdata
);

   logic [gwr_pkg::VAL_W-1:0] grid_mem [gwr_pkg::MAX_SIDE*gwr_pkg::MAX_SIDE];
   logic [gwr_pkg::VAL_W-1:0] win_mem  [gwr_pkg::MAX_SIDE*gwr_pkg::MAX_SIDE];
   logic [gwr_pkg::VAL_W-1:0] grid_rdata_ff;
   logic [gwr_pkg::VAL_W-1:0] win_rdata_ff;
   logic [gwr_pkg::VAL_W-1:0] grid_wdata;

   // write-back words come straight from the scratch read register
   assign grid_wdata = ctl.grid_wsel_win ? win_rdata_ff : ctl.grid_wdata;

   always_ff @(posedge clock) begin
      if (ctl.grid_we) begin
         grid_mem[ctl.grid_waddr] <= grid_wdata;
      end
      grid_rdata_ff <= grid_mem[ctl.grid_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.win_we) begin
         win_mem[ctl.win_waddr] <= grid_rdata_ff;
      end
      win_rdata_ff <= win_mem[ctl.win_raddr];
   end

   assign grid_rdata = grid_rdata_ff;

endmodule

`default_nettype wire

[rtl/gwr_ctrl.sv]
// Sequencer: decodes an operation, walks the cells through the address
// unit and drives the memories. Depends on gwr_pkg and gwr_agen.
`timescale 1ns / 1ps
`default_nettype none

module gwr_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [gwr_pkg::CSR_W-1:0] csr_wr_data,
   input  wire logic                      req_valid,
   input  wire gwr_pkg::req_type          req,
   output logic                           req_ready,
   input  wire logic                      rsp_free,
   output gwr_pkg::res_type               res,
   output gwr_pkg::mem_ctl_type           mem_ctl,
   input  wire logic [gwr_pkg::VAL_W-1:0] grid_rdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_FILL, ST_COPY, ST_GAP, ST_BACK, ST_READ, ST_LATCH, ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [gwr_pkg::CSR_W-1:0]  csr_ff, csr_in;
   logic                       clearing_ff, clearing_in;
   logic [gwr_pkg::CNT_W-1:0]  row_cnt_ff, row_cnt_in;
   logic [gwr_pkg::CNT_W-1:0]  col_cnt_ff, col_cnt_in;
   logic [gwr_pkg::VAL_W-1:0]  fill_val_ff, fill_val_in;
   logic [gwr_pkg::IDX_W-1:0]  rbase_ff, rbase_in;
   logic [gwr_pkg::IDX_W-1:0]  cbase_ff, cbase_in;
   logic [gwr_pkg::CNT_W-1:0]  wm1_ff, wm1_in;
   logic                       dir_ff, dir_in;
   logic [gwr_pkg::VAL_W-1:0]  value_ff, value_in;
   logic                       status_ff, status_in;
   logic                       pend_win_ff, pend_win_in;
   logic                       pend_grid_ff, pend_grid_in;
   logic [gwr_pkg::ADDR_W-1:0] pend_addr_ff, pend_addr_in;

   logic [gwr_pkg::SIDE_W-1:0] side_eff;
   logic [gwr_pkg::CMP_W-1:0]  cr, cc, rd, se;
   logic [gwr_pkg::CMP_W-1:0]  row_lo, col_lo, row_rd, col_rd;
   logic                       rot_ok, read_ok;
   logic [gwr_pkg::CNT_W-1:0]  lim_m1;
   logic                       row_last, col_last, in_area;

   logic [gwr_pkg::IDX_W-1:0]  ag_base_row, ag_base_col;
   logic [gwr_pkg::CNT_W-1:0]  ag_off_row, ag_off_col;
   logic [gwr_pkg::ADDR_W-1:0] ag_grid_addr, ag_win_addr;

   gwr_agen u_agen (
      .base_row  (ag_base_row),
      .base_col  (ag_base_col),
      .off_row   (ag_off_row),
      .off_col   (ag_off_col),
      .win_row   (row_cnt_ff),
      .win_col   (col_cnt_ff),
      .grid_addr (ag_grid_addr),
      .win_addr  (ag_win_addr)
   );

   // clamp the side register to 1..MAX_SIDE
   always_comb begin
      if (csr_ff == '0) begin
         side_eff = gwr_pkg::SIDE_W'(1);
      end else if (gwr_pkg::CMP_W'(csr_ff) > gwr_pkg::CMP_W'(gwr_pkg::MAX_SIDE)) begin
         side_eff = gwr_pkg::SIDE_W'(gwr_pkg::MAX_SIDE);
      end else begin
         side_eff = gwr_pkg::SIDE_W'(csr_ff);
      end
   end

   assign cr = gwr_pkg::CMP_W'(req.center_row);
   assign cc = gwr_pkg::CMP_W'(req.center_col);
   assign rd = gwr_pkg::CMP_W'(req.radius);
   assign se = gwr_pkg::CMP_W'(side_eff);

   assign rot_ok  = (cr > rd) && (cr + rd <= se) && (cc > rd) && (cc + rd <= se);
   assign read_ok = (cr != '0) && (cr <= se) && (cc != '0) && (cc <= se);
   assign row_lo  = cr - rd - gwr_pkg::CMP_W'(1);
   assign col_lo  = cc - rd - gwr_pkg::CMP_W'(1);
   assign row_rd  = cr - gwr_pkg::CMP_W'(1);
   assign col_rd  = cc - gwr_pkg::CMP_W'(1);

   always_comb begin
      if (state_ff == ST_FILL) begin
         lim_m1 = clearing_ff ? gwr_pkg::CNT_W'(gwr_pkg::MAX_SIDE - 1)
                              : gwr_pkg::CNT_W'(side_eff - gwr_pkg::SIDE_W'(1));
      end else begin
         lim_m1 = wm1_ff;
      end
   end

   assign row_last = (row_cnt_ff == lim_m1);
   assign col_last = (col_cnt_ff == lim_m1);
   assign in_area  = !clearing_ff
                   || ((gwr_pkg::CMP_W'(row_cnt_ff) < gwr_pkg::CMP_W'(gwr_pkg::RST_SIDE))
                    && (gwr_pkg::CMP_W'(col_cnt_ff) < gwr_pkg::CMP_W'(gwr_pkg::RST_SIDE)));

   // address unit operand select
   always_comb begin
      ag_base_row = rbase_ff;
      ag_base_col = cbase_ff;
      ag_off_row  = row_cnt_ff;
      ag_off_col  = col_cnt_ff;
      unique case (state_ff)
         ST_FILL: begin
            ag_base_row = '0;
            ag_base_col = '0;
         end
         ST_BACK: begin
            if (!dir_ff) begin
               ag_off_row = col_cnt_ff;
               ag_off_col = wm1_ff - row_cnt_ff;
            end else begin
               ag_off_row = wm1_ff - col_cnt_ff;
               ag_off_col = row_cnt_ff;
            end
         end
         ST_READ: begin
            ag_off_row = '0;
            ag_off_col = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      csr_in       = csr_wr_en ? csr_wr_data : csr_ff;
      clearing_in  = clearing_ff;
      row_cnt_in   = row_cnt_ff;
      col_cnt_in   = col_cnt_ff;
      fill_val_in  = fill_val_ff;
      rbase_in     = rbase_ff;
      cbase_in     = cbase_ff;
      wm1_in       = wm1_ff;
      dir_in       = dir_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      pend_win_in  = 1'b0;
      pend_grid_in = 1'b0;
      pend_addr_in = pend_addr_ff;

      // delayed writes land in the cycle after their read was issued
      mem_ctl               = '0;
      mem_ctl.win_we        = pend_win_ff;
      mem_ctl.win_waddr     = pend_addr_ff;
      mem_ctl.grid_we       = pend_grid_ff;
      mem_ctl.grid_wsel_win = pend_grid_ff;
      mem_ctl.grid_waddr    = pend_addr_ff;
      mem_ctl.grid_raddr    = ag_grid_addr;
      mem_ctl.win_raddr     = ag_win_addr;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               row_cnt_in  = '0;
               col_cnt_in  = '0;
               fill_val_in = gwr_pkg::VAL_W'(1);
               wm1_in      = gwr_pkg::CNT_W'({req.radius, 1'b0});
               dir_in      = req.direction;
               value_in    = '0;
               status_in   = 1'b0;
               case (req.func)
                  gwr_pkg::FUNC_INIT: begin
                     state_in = ST_FILL;
                  end
                  gwr_pkg::FUNC_ROTATE: begin
                     rbase_in = row_lo[gwr_pkg::IDX_W-1:0];
                     cbase_in = col_lo[gwr_pkg::IDX_W-1:0];
                     if (rot_ok) begin
                        state_in = ST_COPY;
                     end else begin
                        status_in = 1'b1;
                        state_in  = ST_DONE;
                     end
                  end
                  gwr_pkg::FUNC_READ: begin
                     rbase_in = row_rd[gwr_pkg::IDX_W-1:0];
                     cbase_in = col_rd[gwr_pkg::IDX_W-1:0];
                     if (read_ok) begin
                        state_in = ST_READ;
                     end else begin
                        status_in = 1'b1;
                        state_in  = ST_DONE;
                     end
                  end
                  default: begin
                     status_in = 1'b1;
                     state_in  = ST_DONE;
                  end
               endcase
            end
         end
         ST_FILL: begin
            mem_ctl.grid_we       = 1'b1;
            mem_ctl.grid_wsel_win = 1'b0;
            mem_ctl.grid_waddr    = ag_grid_addr;
            mem_ctl.grid_wdata    = in_area ? fill_val_ff : '0;
            if (in_area) begin
               fill_val_in = fill_val_ff + gwr_pkg::VAL_W'(1);
            end
            col_cnt_in = col_last ? '0 : col_cnt_ff + gwr_pkg::CNT_W'(1);
            if (col_last) begin
               row_cnt_in = row_cnt_ff + gwr_pkg::CNT_W'(1);
               if (row_last) begin
                  clearing_in = 1'b0;
                  state_in    = clearing_ff ? ST_IDLE : ST_DONE;
               end
            end
         end
         ST_COPY: begin
            pend_win_in  = 1'b1;
            pend_addr_in = ag_win_addr;
            col_cnt_in   = col_last ? '0 : col_cnt_ff + gwr_pkg::CNT_W'(1);
            if (col_last) begin
               row_cnt_in = row_cnt_ff + gwr_pkg::CNT_W'(1);
               if (row_last) begin
                  row_cnt_in = '0;
                  state_in   = ST_GAP;
               end
            end
         end
         ST_GAP: begin
            // let the last scratch write land before reading back
            state_in = ST_BACK;
         end
         ST_BACK: begin
            pend_grid_in = 1'b1;
            pend_addr_in = ag_grid_addr;
            col_cnt_in   = col_last ? '0 : col_cnt_ff + gwr_pkg::CNT_W'(1);
            if (col_last) begin
               row_cnt_in = row_cnt_ff + gwr_pkg::CNT_W'(1);
               if (row_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            value_in = grid_rdata;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         csr_ff       <= gwr_pkg::CSR_RST;
         clearing_ff  <= 1'b1;
         row_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         fill_val_ff  <= gwr_pkg::VAL_W'(1);
         pend_win_ff  <= 1'b0;
         pend_grid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         clearing_ff  <= clearing_in;
         row_cnt_ff   <= row_cnt_in;
         col_cnt_ff   <= col_cnt_in;
         fill_val_ff  <= fill_val_in;
         pend_win_ff  <= pend_win_in;
         pend_grid_ff <= pend_grid_in;
      end
      rbase_ff     <= rbase_in;
      cbase_ff     <= cbase_in;
      wm1_ff       <= wm1_in;
      dir_ff       <= dir_in;
      value_ff     <= value_in;
      status_ff    <= status_in;
      pend_addr_ff <= pend_addr_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign res.valid      = (state_ff == ST_DONE);
   assign res.cell_value = value_ff;
   assign res.status     = status_ff;

endmodule

`default_nettype wire

[rtl/grid_window_rotator_unit.sv]
// Grid window rotator: keeps a square grid of up to MAX_SIDE x MAX_SIDE
// 11-bit cells and runs one operation per request word: initialize the grid
// to row*side+col+1, rotate a (2*radius+1)-square window 90 degrees about a
// 1-based centre, or read one cell. Windows or reads outside the grid in use
// leave it unchanged and answer status 1. One request is in work at a time;
// a rotation copies the window to scratch through the grid's read port and
// writes it back rotated, one cell per cycle each way. An unknown func code
// answers status 1. After reset the grid is swept once before the first
// request is taken. Depends on gwr_pkg, gwr_ctrl, gwr_agen and gwr_store.
`timescale 1ns / 1ps
`default_nettype none

module grid_window_rotator_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [gwr_pkg::CSR_W-1:0] csr_wr_data,  // grid_side
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // func[1:0], center_row[7:2], center_col[13:8], radius[17:14], direction[18]
   input  wire logic [23:0]               req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // cell_value[10:0], status[11]
   output logic      [15:0]               rsp_tdata
);

   gwr_pkg::req_type     req;
   gwr_pkg::res_type     res;
   gwr_pkg::mem_ctl_type mem_ctl;
   logic [gwr_pkg::VAL_W-1:0] grid_rdata;
   logic                      rsp_free;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [gwr_pkg::VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic                      rsp_status_ff, rsp_status_in;

   assign req.func       = req_tdata[1:0];
   assign req.center_row = req_tdata[7:2];
   assign req.center_col = req_tdata[13:8];
   assign req.radius     = req_tdata[17:14];
   assign req.direction  = req_tdata[18];

   gwr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_tvalid),
      .req         (req),
      .req_ready   (req_tready),
      .rsp_free    (rsp_free),
      .res         (res),
      .mem_ctl     (mem_ctl),
      .grid_rdata  (grid_rdata)
   );

   gwr_store u_store (
      .clock      (clock),
      .ctl        (mem_ctl),
      .grid_rdata (grid_rdata)
   );

   // output word register: free once empty or being taken
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (res.valid && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res.cell_value;
         rsp_status_in = res.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_status_ff, rsp_value_ff};

endmodule

`default_nettype wire
